>>> sv/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

  localparam int unsigned AW = 32;
  localparam int unsigned CW = 9;
  localparam logic [AW-1:0] PAGE_ADD  = 32'h0000_0fff;
  localparam logic [AW-1:0] PAGE_MASK = 32'hffff_f000;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_LOST    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_SHL    = 2'd1,
    OP_SHR    = 2'd2
  } shift_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_OUT  = 2'd2
  } state_e;

  // per-cell flags fed back from the row
  typedef struct packed {
    logic valid;
    logic fit;
    logic above;
    logic end_eq;
    logic start_eq;
  } cell_flag_t;

  // per-cell command from the sequencer
  typedef struct packed {
    shift_e          shift;
    logic            wr;
    logic [AW-1:0]   wr_start;
    logic [AW-1:0]   wr_size;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> sv/ffa_cell.sv
`default_nettype none
module ffa_cell import ffa_pkg::*; (
  input  wire logic          clk_i,
  input  wire cell_cmd_t     cmd_i,
  input  wire logic [AW-1:0] key_addr_i,
  input  wire logic [AW-1:0] key_end_i,
  input  wire logic [AW-1:0] key_size_i,
  input  wire logic [AW-1:0] lo_start_i,
  input  wire logic [AW-1:0] lo_size_i,
  input  wire logic [AW-1:0] hi_start_i,
  input  wire logic [AW-1:0] hi_size_i,
  output logic [AW-1:0]      start_o,
  output logic [AW-1:0]      size_o,
  output logic               fit_o,
  output logic               above_o,
  output logic               end_eq_o,
  output logic               start_eq_o
);

  logic [AW-1:0] start_q, start_d, size_q, size_d;

  always_comb begin
    start_d = start_q;
    size_d  = size_q;
    if (cmd_i.wr) begin
      start_d = cmd_i.wr_start;
      size_d  = cmd_i.wr_size;
    end else begin
      case (cmd_i.shift)
        OP_SHL: begin
          start_d = hi_start_i;
          size_d  = hi_size_i;
        end
        OP_SHR: begin
          start_d = lo_start_i;
          size_d  = lo_size_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    size_q  <= size_d;
  end

  assign start_o    = start_q;
  assign size_o     = size_q;
  assign fit_o      = size_q >= key_size_i;
  assign above_o    = start_q > key_addr_i;
  assign end_eq_o   = (start_q + size_q) == key_addr_i;
  assign start_eq_o = start_q == key_end_i;

endmodule
`default_nettype wire

>>> sv/ffa_ctrl.sv
`default_nettype none
module ffa_ctrl import ffa_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned IW = $clog2(TABLE_DEPTH),
  parameter int unsigned NW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           func_i,
  input  wire logic [AW-1:0]  addr_i,
  input  wire logic [AW-1:0]  size_i,
  input  wire cell_flag_t     flag_i [TABLE_DEPTH],
  input  wire logic [AW-1:0]  start_row_i [TABLE_DEPTH],
  input  wire logic [AW-1:0]  size_row_i [TABLE_DEPTH],
  output cell_cmd_t           cmd_o [TABLE_DEPTH],
  output logic [AW-1:0]       grant_o,
  output status_e             status_o,
  output logic [AW-1:0]       total_o,
  output logic [NW-1:0]       count_o,
  output logic [NW-1:0]       peak_o,
  output logic [AW-1:0]       lost_n_o,
  output logic [AW-1:0]       lost_b_o
);

  logic [AW-1:0] total_q, lost_n_q, lost_b_q;
  logic [NW-1:0] count_q, peak_q;
  logic [AW-1:0] grant_d, total_d, lost_n_d, lost_b_d;
  logic [NW-1:0] count_d, peak_d;
  status_e       status_d;

  // first-match and insert-position encoders over the row
  logic          fit_any, pos_any;
  logic [IW-1:0] fit_idx, pos_idx;
  logic [NW-1:0] pos;

  always_comb begin
    fit_any = 1'b0;
    fit_idx = '0;
    pos_any = 1'b0;
    pos_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (flag_i[i].valid && flag_i[i].fit) begin
        fit_any = 1'b1;
        fit_idx = IW'(i);
      end
      if (flag_i[i].valid && flag_i[i].above) begin
        pos_any = 1'b1;
        pos_idx = IW'(i);
      end
    end
    pos = pos_any ? NW'(pos_idx) : count_q;
  end

  logic          has_prev, has_next, mprev, mnext;
  logic [IW-1:0] prev_idx;
  assign prev_idx = IW'(pos - NW'(1));
  assign has_prev = pos != '0;
  assign has_next = pos_any;
  assign mprev    = has_prev && flag_i[prev_idx].end_eq;
  assign mnext    = has_next && flag_i[pos_idx].start_eq;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cmd_o[i].shift    = OP_HOLD;
      cmd_o[i].wr       = 1'b0;
      cmd_o[i].wr_start = start_row_i[i];
      cmd_o[i].wr_size  = size_row_i[i];
    end
    grant_d  = '0;
    status_d = ST_DONE;
    total_d  = total_q;
    count_d  = count_q;
    peak_d   = peak_q;
    lost_n_d = lost_n_q;
    lost_b_d = lost_b_q;
    if (start_i) begin
      if (!func_i) begin
        if (fit_any) begin
          grant_d = start_row_i[fit_idx];
          total_d = total_q - size_i;
          if (size_row_i[fit_idx] == size_i) begin
            count_d = count_q - NW'(1);
            for (int i = 0; i < TABLE_DEPTH; i++)
              if (IW'(i) >= fit_idx && i < TABLE_DEPTH - 1) cmd_o[i].shift = OP_SHL;
          end else begin
            cmd_o[fit_idx].wr       = 1'b1;
            cmd_o[fit_idx].wr_start = start_row_i[fit_idx] + size_i;
            cmd_o[fit_idx].wr_size  = size_row_i[fit_idx] - size_i;
          end
        end else begin
          status_d = ST_NOFIT;
        end
      end else if (mprev) begin
        total_d = total_q + size_i;
        cmd_o[prev_idx].wr = 1'b1;
        if (mnext) begin
          cmd_o[prev_idx].wr_size = size_row_i[prev_idx] + size_i + size_row_i[pos_idx];
          count_d = count_q - NW'(1);
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (IW'(i) >= pos_idx && i < TABLE_DEPTH - 1) cmd_o[i].shift = OP_SHL;
        end else begin
          cmd_o[prev_idx].wr_size = size_row_i[prev_idx] + size_i;
        end
      end else if (mnext) begin
        total_d = total_q + size_i;
        cmd_o[pos_idx].wr       = 1'b1;
        cmd_o[pos_idx].wr_start = addr_i;
        cmd_o[pos_idx].wr_size  = size_row_i[pos_idx] + size_i;
      end else if (count_q < NW'(TABLE_DEPTH)) begin
        total_d = total_q + size_i;
        count_d = count_q + NW'(1);
        if (peak_q < count_d) peak_d = count_d;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (NW'(i) > pos) cmd_o[i].shift = OP_SHR;
          if (NW'(i) == pos) begin
            cmd_o[i].wr       = 1'b1;
            cmd_o[i].wr_start = addr_i;
            cmd_o[i].wr_size  = size_i;
          end
        end
      end else begin
        status_d = ST_LOST;
        lost_n_d = lost_n_q + AW'(1);
        lost_b_d = lost_b_q + size_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      count_q  <= '0;
      peak_q   <= '0;
      lost_n_q <= '0;
      lost_b_q <= '0;
    end else begin
      total_q  <= total_d;
      count_q  <= count_d;
      peak_q   <= peak_d;
      lost_n_q <= lost_n_d;
      lost_b_q <= lost_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      grant_o  <= grant_d;
      status_o <= status_d;
    end
  end

  assign total_o  = total_q;
  assign count_o  = count_q;
  assign peak_o   = peak_q;
  assign lost_n_o = lost_n_q;
  assign lost_b_o = lost_b_q;

endmodule
`default_nettype wire

>>> sv/first_fit_free_list_allocator.sv
`default_nettype none
// First-fit region allocator. Free regions sit in a row of cells sorted by
// start address; every cell compares itself against the request at once and
// the row shifts by one place to open or close a gap. EXEC updates the row
// and counters; OUT presents the result in the output register. A new
// request is taken as soon as that register is empty or being drained, so
// no request is taken before the last result leaves. Status 0 done,
// 1 no fit, 2 free lost (table full).
module first_fit_free_list_allocator import ffa_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,  // region_addr, region_size
  input  wire logic [1:0]   s_axis_tuser,  // func, round_pages
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [151:0]      m_axis_tdata   // alloc_addr, status, free_total,
                                           // entries_used, entries_peak,
                                           // lost_count, lost_bytes
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);

  state_e state_q, state_d;
  logic   take, start;
  logic   func_q;
  logic [AW-1:0] addr_q, size_q, size_r;

  assign size_r = s_axis_tuser[1] ? ((s_axis_tdata[63:32] + PAGE_ADD) & PAGE_MASK)
                                  : s_axis_tdata[63:32];
  assign take  = s_axis_tvalid && s_axis_tready;
  assign start = state_q == S_EXEC;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (take) state_d = S_EXEC;
      S_EXEC: state_d = S_OUT;
      S_OUT:  if (m_axis_tready) state_d = take ? S_EXEC : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == S_IDLE) || (state_q == S_OUT && m_axis_tready);
    m_axis_tvalid = state_q == S_OUT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      func_q <= s_axis_tuser[0];
      addr_q <= s_axis_tdata[31:0];
      size_q <= size_r;
    end
  end

  cell_flag_t    flag [TABLE_DEPTH];
  cell_cmd_t     cmd  [TABLE_DEPTH];
  logic [AW-1:0] st_row [TABLE_DEPTH];
  logic [AW-1:0] sz_row [TABLE_DEPTH];
  logic [NW-1:0] count;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ffa_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd[g]),
      .key_addr_i (addr_q),
      .key_end_i  (addr_q + size_q),
      .key_size_i (size_q),
      .lo_start_i (st_row[(g == 0) ? 0 : g - 1]),
      .lo_size_i  (sz_row[(g == 0) ? 0 : g - 1]),
      .hi_start_i (st_row[(g == TABLE_DEPTH - 1) ? g : g + 1]),
      .hi_size_i  (sz_row[(g == TABLE_DEPTH - 1) ? g : g + 1]),
      .start_o    (st_row[g]),
      .size_o     (sz_row[g]),
      .fit_o      (flag[g].fit),
      .above_o    (flag[g].above),
      .end_eq_o   (flag[g].end_eq),
      .start_eq_o (flag[g].start_eq)
    );
    assign flag[g].valid = NW'(g) < count;
  end

  logic [AW-1:0] grant, total, lost_n, lost_b;
  logic [NW-1:0] peak;
  status_e       status;

  ffa_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .IW(IW), .NW(NW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .func_i      (func_q),
    .addr_i      (addr_q),
    .size_i      (size_q),
    .flag_i      (flag),
    .start_row_i (st_row),
    .size_row_i  (sz_row),
    .cmd_o       (cmd),
    .grant_o     (grant),
    .status_o    (status),
    .total_o     (total),
    .count_o     (count),
    .peak_o      (peak),
    .lost_n_o    (lost_n),
    .lost_b_o    (lost_b)
  );

  logic [CW-1:0] used9, peak9;
  if (NW >= CW) begin : g_wide
    assign used9 = count[CW-1:0];
    assign peak9 = peak[CW-1:0];
  end else begin : g_narrow
    assign used9 = CW'(count);
    assign peak9 = CW'(peak);
  end

  assign m_axis_tdata = {4'b0000, lost_b, lost_n, peak9, used9, total, status, grant};

endmodule
`default_nettype wire

>>> sv/ffa_checker.sv
`default_nettype none
module ffa_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [151:0] m_axis_tdata
);

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
    else $error("bad status");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33:32] != 2'd0 |-> m_axis_tdata[31:0] == 32'd0)
    else $error("failed request gave address");

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[74:66] <= m_axis_tdata[83:75] ||
      m_axis_tdata[83:75] == 9'd0)
    else $error("count above peak");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result before work done");

endmodule

bind first_fit_free_list_allocator ffa_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> tb/tb_first_fit_free_list_allocator.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_first_fit_free_list_allocator;
  import ffa_pkg::*;

  typedef struct {
    logic        func;
    logic        rnd;
    logic [31:0] addr;
    logic [31:0] size;
    bit          drain;
  } request_t;

  typedef struct {
    logic [31:0] grant;
    status_e     status;
    logic [31:0] total;
    logic [8:0]  used;
    logic [8:0]  peak;
    logic [31:0] lcount;
    logic [31:0] lbytes;
  } outcome_t;

  localparam int DEPTH = 256;
  localparam int WATCHDOG = 4000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  wire          s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;   // region_addr, region_size
  logic [1:0]   s_axis_tuser = '0;   // func, round_pages
  wire          m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  wire  [151:0] m_axis_tdata;        // alloc_addr, status, free_total, entries_used,
                                     // entries_peak, lost_count, lost_bytes

  first_fit_free_list_allocator #(.TABLE_DEPTH(DEPTH)) uut (.*);

  request_t    pending[$];
  outcome_t    awaited[$];
  request_t    cur;
  logic [31:0] rg_start [DEPTH];
  logic [31:0] rg_size  [DEPTH];
  int unsigned rg_count, rg_peak;
  logic [31:0] lost_n, lost_b, free_sum;
  int          errors, n_results, n_allocs, n_frees, n_nofit, n_lost;
  int          gap, burst, idle_cycles, long_cnt;
  bit          long_done;

  initial forever #1 clk_i = ~clk_i;

  function automatic void drop_region(int unsigned pos);
    rg_count--;
    for (int unsigned k = pos; k < rg_count; k++) begin
      rg_start[k] = rg_start[k+1];
      rg_size[k]  = rg_size[k+1];
    end
  endfunction

  function automatic outcome_t allocator_step(request_t r);
    outcome_t    o;
    logic [31:0] sz;
    logic [31:0] fin;
    int unsigned pos;
    bit          hit;
    sz = r.rnd ? ((r.size + PAGE_ADD) & PAGE_MASK) : r.size;
    o.grant = '0;
    o.status = ST_DONE;
    if (!r.func) begin
      hit = 0;
      for (int unsigned k = 0; k < rg_count && !hit; k++) begin
        if (rg_size[k] >= sz) begin
          hit = 1;
          o.grant = rg_start[k];
          rg_start[k] += sz;
          rg_size[k] -= sz;
          free_sum -= sz;
          if (rg_size[k] == 0) drop_region(k);
        end
      end
      if (!hit) o.status = ST_NOFIT;
    end else begin
      fin = r.addr + sz;
      pos = 0;
      while (pos < rg_count && !(rg_start[pos] > r.addr)) pos++;
      if (pos > 0 && rg_start[pos-1] + rg_size[pos-1] == r.addr) begin
        rg_size[pos-1] += sz;
        if (pos < rg_count && fin == rg_start[pos]) begin
          rg_size[pos-1] += rg_size[pos];
          drop_region(pos);
        end
        free_sum += sz;
      end else if (pos < rg_count && fin == rg_start[pos]) begin
        rg_start[pos] = r.addr;
        rg_size[pos] += sz;
        free_sum += sz;
      end else if (rg_count < DEPTH) begin
        for (int unsigned k = rg_count; k > pos; k--) begin
          rg_start[k] = rg_start[k-1];
          rg_size[k]  = rg_size[k-1];
        end
        rg_count++;
        if (rg_peak < rg_count) rg_peak = rg_count;
        rg_start[pos] = r.addr;
        rg_size[pos] = sz;
        free_sum += sz;
      end else begin
        lost_n++;
        lost_b += sz;
        o.status = ST_LOST;
      end
    end
    o.total = free_sum;
    o.used = rg_count[8:0];
    o.peak = rg_peak[8:0];
    o.lcount = lost_n;
    o.lbytes = lost_b;
    return o;
  endfunction

  task automatic add(logic func, logic rnd, logic [31:0] addr, logic [31:0] size,
                     bit drain = 0);
    request_t r;
    r.func = func; r.rnd = rnd; r.addr = addr; r.size = size; r.drain = drain;
    pending.push_back(r);
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return 32'hffff_ffff - $urandom_range(0, 32'h1000);
      2:       return 0;
      default: return $urandom_range(0, 32'h3000);
    endcase
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return 32'hffff_ffff - $urandom_range(0, 32'h3000);
      default: return $urandom_range(0, 32'h400) << 8;
    endcase
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited.push_back(allocator_step(cur));
        if (cur.func) n_frees++; else n_allocs++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap > 0) begin
          gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending.size() == 0 || (pending[0].drain && awaited.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          cur = pending.pop_front();
          s_axis_tdata  <= {cur.size, cur.addr};
          s_axis_tuser  <= {cur.rnd, cur.func};
          s_axis_tvalid <= 1'b1;
          if (burst > 0) burst--;
          else begin
            burst = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          e = awaited.pop_front();
          if (m_axis_tdata[33:32] == ST_NOFIT) n_nofit++;
          if (m_axis_tdata[33:32] == ST_LOST) n_lost++;
          if (m_axis_tdata[31:0] !== e.grant)
            begin $display("%0t: alloc_addr expected %h actual %h", $realtime, e.grant,
              m_axis_tdata[31:0]); errors++; end
          if (m_axis_tdata[33:32] !== e.status)
            begin $display("%0t: status expected %0d actual %0d", $realtime, e.status,
              m_axis_tdata[33:32]); errors++; end
          if (m_axis_tdata[65:34] !== e.total)
            begin $display("%0t: free_total expected %h actual %h", $realtime, e.total,
              m_axis_tdata[65:34]); errors++; end
          if (m_axis_tdata[74:66] !== e.used)
            begin $display("%0t: entries_used expected %0d actual %0d", $realtime, e.used,
              m_axis_tdata[74:66]); errors++; end
          if (m_axis_tdata[83:75] !== e.peak)
            begin $display("%0t: entries_peak expected %0d actual %0d", $realtime, e.peak,
              m_axis_tdata[83:75]); errors++; end
          if (m_axis_tdata[115:84] !== e.lcount)
            begin $display("%0t: lost_count expected %h actual %h", $realtime, e.lcount,
              m_axis_tdata[115:84]); errors++; end
          if (m_axis_tdata[147:116] !== e.lbytes)
            begin $display("%0t: lost_bytes expected %h actual %h", $realtime, e.lbytes,
              m_axis_tdata[147:116]); errors++; end
        end
      end
      if (long_cnt > 0) begin
        long_cnt--;
        m_axis_tready <= 1'b0;
      end else if (!long_done && n_results >= 120) begin
        long_done = 1;
        long_cnt = 400;
        m_axis_tready <= 1'b0;
      end else if (n_results >= 250 && n_results < 300) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else if (pending.size() != 0 || awaited.size() != 0 || s_axis_tvalid)
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: timeout", $realtime);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rg_count = 0; rg_peak = 0; lost_n = 0; lost_b = 0; free_sum = 0;
    errors = 0; n_results = 0; n_allocs = 0; n_frees = 0; n_nofit = 0; n_lost = 0;
    gap = 0; burst = 0; idle_cycles = 0; long_cnt = 0; long_done = 0;

    // directed: empty table, zero sizes, page rounding, merges, wrap
    add(0, 0, 0, 32'h100);
    add(0, 0, 32'hffff_ffff, 0);
    add(1, 0, 0, 32'h2000);
    add(0, 0, 0, 0);
    add(0, 1, 0, 32'h10);
    add(1, 0, 0, 32'h1000);
    add(1, 0, 32'h2000, 32'h800);
    add(1, 0, 32'h4000, 32'h100);
    add(1, 0, 32'h2800, 32'h1800);
    add(1, 0, 32'hffff_ff00, 32'h100);
    add(1, 0, 32'h1_0000, 0);
    add(0, 0, 0, 0);
    add(0, 1, 0, 32'hffff_ffff);
    add(0, 0, 0, 32'h4100);
    add(1, 1, 32'hffff_f000, 32'hffff_ffff);
    add(1, 0, 32'h8000_0000, 32'hffff_ffff);
    add(0, 0, 0, 32'hffff_ffff);
    add(0, 1, 0, 32'hffff_f001);
    add(1, 1, 32'h5000, 32'h1);
    add(0, 0, 0, 1);
    add(0, 0, 0, 32'h7fff_ffff);

    for (int i = 0; i < 60; i++)
      add($urandom_range(0, 1), $urandom_range(0, 3) == 0, pick_addr(), pick_size(), i == 40);
    // spaced frees fill the table until frees are lost
    for (int i = 0; i < 270; i++)
      add(1, $urandom_range(0, 3) == 0, 32'h4000_0000 + i * 32'h1_0000 + $urandom_range(0, 255),
          $urandom_range(1, 32'h800), i == 0);
    for (int i = 0; i < 50; i++)
      add($urandom_range(0, 2) != 0, $urandom_range(0, 3) == 0, pick_addr(), pick_size());

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending.size() != 0 || s_axis_tvalid || awaited.size() != 0);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d allocates (%0d without fit) and %0d frees (%0d lost), peak %0d.",
             n_allocs, n_nofit, n_frees, n_lost, rg_peak);
    if (errors == 0 && awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
sv/ffa_pkg.sv
sv/ffa_cell.sv
sv/ffa_ctrl.sv
sv/first_fit_free_list_allocator.sv
sv/ffa_checker.sv
tb/tb_first_fit_free_list_allocator.sv
